FILE: sv/dmm_pkg.sv
// ============================================================================
// dmm_pkg
// Shared types and constants for the byte data set statistics block.
// ============================================================================
package dmm_pkg;

    localparam int SAMPLE_W    = 8;
    localparam int COUNT_OUT_W = 7;
    localparam int RESULT_W    = 4 * SAMPLE_W + COUNT_OUT_W + 1;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

    typedef logic [SAMPLE_W-1:0] sample_t;

    // Broadcast control for the sorted chain
    typedef struct packed {
        logic    insert;
        logic    drain;
        sample_t sample;
    } dmm_ctl_t;

    typedef enum logic [1:0] {
        ST_COLLECT = 2'b01,
        ST_FINAL   = 2'b10
    } dmm_state_t;

endpackage

FILE: sv/dataset_min_max_mean_median.sv
// ============================================================================
// dataset_min_max_mean_median
// Min, max, floored mean and median over a byte data set ended by tlast.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                                         side
//  s_*      in   sample[7:0]                                   tlast=last_sample
//  m_*      out  min, max, mean, median, sample_count, ovf    none
//
//  One byte per cycle enters the sorted chain while collecting.
//  After the last byte, finishing waits for the serial divider and the
//  chain drain; s_tready is low meanwhile, and finishing also waits while
//  an earlier result is still unsent.
//  Reset clears counts and flags; chain contents need no reset.
// ============================================================================
module dataset_min_max_mean_median
    import dmm_pkg::*;
#(
    parameter int MAX_SAMPLES = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,  // sample
    input  logic                s_tlast,  // last_sample
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [RESULT_W-1:0] m_tdata   // minimum, maximum, mean, median,
                                          // sample_count[6:0], overflowed
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = SAMPLE_W + CNT_W;

    dmm_state_t        state_reg;
    dmm_state_t        state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    sample_t           min_reg;
    sample_t           min_next;
    sample_t           max_reg;
    sample_t           max_next;
    logic              ovf_reg;
    logic              ovf_next;
    logic [CNT_W-1:0]  step_reg;
    logic [CNT_W-1:0]  step_next;
    sample_t           med_a_reg;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic [RESULT_W-1:0] m_data_reg;

    logic              accept;
    logic              keep;
    logic              finish;
    logic [CNT_W-1:0]  half;
    logic              even;
    logic [SAMPLE_W:0] med_sum;
    sample_t           median;
    logic [CNT_W+COUNT_OUT_W-1:0] count_ext;
    dmm_ctl_t          ctl;
    logic              div_busy;
    logic [SUM_W-1:0]  quotient;

    sample_t           vals [MAX_SAMPLES];
    logic              gts  [MAX_SAMPLES];

    assign s_tready = (state_reg == ST_COLLECT);
    assign accept   = s_tvalid && s_tready;
    assign keep     = accept && (count_reg < CNT_W'(MAX_SAMPLES));
    assign half     = count_reg >> 1;
    assign even     = !count_reg[0];
    assign finish   = (state_reg == ST_FINAL) && (step_reg == half) && !div_busy
                      && (!m_valid_reg || m_tready);

    // drain stops once cell 0 holds the middle element
    assign ctl.insert = keep;
    assign ctl.drain  = (state_reg == ST_FINAL) && (step_reg != half);
    assign ctl.sample = s_tdata;

    // sorted chain, cell 0 holds the smallest value
    for (genvar i = 0; i < MAX_SAMPLES; i++)
    begin : g_cell
        dmm_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .occupied   (CNT_W'(i) < count_reg),
            .first_free (CNT_W'(i) == count_reg),
            .left_val   ((i == 0) ? vals[0] : vals[(i == 0) ? 0 : i-1]),
            .left_gt    ((i == 0) ? 1'b0 : gts[(i == 0) ? 0 : i-1]),
            .right_val  (vals[(i == MAX_SAMPLES-1) ? i : i+1]),
            .val        (vals[i]),
            .gt         (gts[i])
        );
    end

    dmm_div #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept && s_tlast),
        .dividend (sum_next),
        .divisor  (count_next),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign med_sum   = {1'b0, med_a_reg} + {1'b0, vals[0]};
    assign median    = even ? med_sum[SAMPLE_W:1] : vals[0];
    assign count_ext = {{COUNT_OUT_W{1'b0}}, count_reg};

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        ovf_next     = ovf_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg && !m_tready;
        unique case (state_reg)
            ST_COLLECT:
            begin
                if (keep)
                begin
                    count_next = count_reg + 1'b1;
                    sum_next   = sum_reg + SUM_W'(s_tdata);
                    if (s_tdata < min_reg)
                    begin
                        min_next = s_tdata;
                    end
                    if (s_tdata > max_reg)
                    begin
                        max_next = s_tdata;
                    end
                end
                else if (accept)
                begin
                    ovf_next = 1'b1;
                end
                if (accept && s_tlast)
                begin
                    state_next = ST_FINAL;
                    step_next  = '0;
                end
            end
            ST_FINAL:
            begin
                if (step_reg != half)
                begin
                    step_next = step_reg + 1'b1;
                end
                if (finish)
                begin
                    state_next   = ST_COLLECT;
                    m_valid_next = 1'b1;
                    count_next   = '0;
                    sum_next     = '0;
                    min_next     = SAMPLE_MAX;
                    max_next     = '0;
                    ovf_next     = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_COLLECT;
            count_reg   <= '0;
            sum_reg     <= '0;
            min_reg     <= SAMPLE_MAX;
            max_reg     <= '0;
            ovf_reg     <= 1'b0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            min_reg     <= min_next;
            max_reg     <= max_next;
            ovf_reg     <= ovf_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // cell 0 shows sorted[step] during the drain
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_FINAL) && (step_reg == half - 1'b1))
        begin
            med_a_reg <= vals[0];
        end
        if (finish)
        begin
            m_data_reg <= {ovf_reg, count_ext[COUNT_OUT_W-1:0], median,
                           quotient[SAMPLE_W-1:0], max_reg, min_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

FILE: sv/dmm_cell.sv
// ============================================================================
// dmm_cell
// One slot of the ascending sorted chain: insert with shift-up, drain down.
// ============================================================================
module dmm_cell
    import dmm_pkg::*;
(
    input  logic     clk,
    input  dmm_ctl_t ctl,
    input  logic     occupied,
    input  logic     first_free,
    input  sample_t  left_val,
    input  logic     left_gt,
    input  sample_t  right_val,
    output sample_t  val,
    output logic     gt
);

    sample_t val_reg;
    sample_t val_next;

    assign gt  = occupied && (val_reg > ctl.sample);
    assign val = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (ctl.insert)
        begin
            if (left_gt)
            begin
                val_next = left_val;
            end
            else if (gt || first_free)
            begin
                val_next = ctl.sample;
            end
        end
        else if (ctl.drain)
        begin
            val_next = right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

FILE: sv/dmm_div.sv
// ============================================================================
// dmm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
module dmm_div #(
    parameter int DVD_W = 15,
    parameter int DVS_W = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic [DVD_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  rem_next;
    logic [DVD_W-1:0]  quo_reg;
    logic [DVD_W-1:0]  quo_next;
    logic [DVS_W-1:0]  dvs_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [STEP_W-1:0] cnt_next;
    logic              busy_reg;
    logic              busy_next;
    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    diff;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = STEP_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = diff[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != STEP_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

FILE: sv/dmm_chk.sv
// ============================================================================
// dmm_chk
// Port-level checks for the data set statistics block.
// ============================================================================
module dmm_chk
    import dmm_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                s_tlast,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [RESULT_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_stop_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken during finish");

    a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:0] <= m_tdata[23:16] && m_tdata[23:16] <= m_tdata[15:8])
        else $error("mean outside min..max");

    a_median_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:0] <= m_tdata[31:24] && m_tdata[31:24] <= m_tdata[15:8])
        else $error("median outside min..max");

endmodule

bind dataset_min_max_mean_median dmm_chk u_dmm_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
